[rtl/lspe_pkg.sv]
// Shared constants for the LED strip pattern engine.
`timescale 1ns / 1ps
package lspe_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int TIME_W     = 16;
	localparam int COUNT_W    = 6;
	localparam int RGB_W      = 24;
	localparam int OUT_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE       = 3'd0,
		REG_BASE_RED   = 3'd1,
		REG_BASE_GREEN = 3'd2,
		REG_BASE_BLUE  = 3'd3,
		REG_LED_MASK   = 3'd4,
		REG_LED_COUNT  = 3'd5,
		REG_HALF_PER   = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_STEADY = 2'd1,
		MODE_PULSE  = 2'd2,
		MODE_CHASER = 2'd3
	} mode_t;

	localparam logic KIND_TICK    = 1'b0;
	localparam logic KIND_RESTART = 1'b1;

endpackage

[rtl/lspe_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module lspe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                           wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                           rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

[rtl/led_strip_pattern_engine_core.sv]
// Top level of the LED strip pattern engine: colour store, pattern sequencer, output register.
// Restart request: taken with no result. Tick request: chaser passes through the set and clear
// states when the cursor matches the request time; pulse runs one multiply and eight divider
// steps per channel on one shared divider; then each of the n LEDs takes a store read, then a
// modify and write back that waits for a free output register; one request at a time.
// Reset returns control state to its defaults and clears the per-entry valid bits, so the store reads as zero.
`timescale 1ns / 1ps
module led_strip_pattern_engine_core #(
	parameter int MAX_LEDS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lspe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lspe_pkg::CFG_DATA_W-1:0]     cfg_data,
	// request stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lspe_pkg::TIME_W-1:0]         s_tdata,   // [15:0] time_req
	input  logic                                s_tuser,   // [0] kind
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [lspe_pkg::OUT_DATA_W-1:0]     m_tdata,   // [4:0] led_index, [12:5] red,
	                                                       // [20:13] green, [28:21] blue, 0 above
	output logic                                m_tlast,   // last
	output logic                                m_tuser    // [0] finished
);
	import lspe_pkg::*;

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CH_SET,
		ST_CH_CLR,
		ST_P_MUL,
		ST_P_DIV,
		ST_RD,
		ST_WB
	} state_t;

	// configuration registers
	mode_t               mode_q;
	logic [7:0]          base_r_q, base_g_q, base_b_q;
	logic [31:0]         mask_q;
	logic [COUNT_W-1:0]  count_q;
	logic [TIME_W-1:0]   half_q;

	// sequencer state
	state_t              state_q;
	mode_t               tmode_q;
	logic [TIME_W-1:0]   pos_q;
	logic [TIME_W-1:0]   num_q;
	logic [COUNT_W-1:0]  n_q;
	logic [COUNT_W-1:0]  i_q;
	logic                fin_q;
	logic [1:0]          ch_q;
	logic [2:0]          step_q;
	logic [TIME_W-1:0]   rem_q;
	logic [7:0]          dvd_q;
	logic [7:0]          pr_q, pg_q, pb_q;
	logic [MAX_LEDS-1:0] valid_q;
	logic                rvalid_q;

	// output register
	logic                out_valid_q;
	logic [4:0]          out_idx_q;
	logic [7:0]          out_r_q, out_g_q, out_b_q;
	logic                out_last_q, out_fin_q;

	// store port signals
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [RGB_W-1:0]    wr_data;
	logic [RGB_W-1:0]    rd_data;

	logic [TIME_W-1:0]   half_eff;
	logic [TIME_W:0]     full_per;
	logic [COUNT_W-1:0]  n_eff;
	logic [TIME_W-1:0]   t_in;
	logic [TIME_W-1:0]   num_in;
	logic                fin_in;
	logic [7:0]          chan;
	logic [23:0]         prod;
	logic [TIME_W:0]     trial;
	logic                ge;
	logic [RGB_W-1:0]    base_rgb;
	logic [RGB_W-1:0]    stored;
	logic [RGB_W-1:0]    new_rgb;
	logic                masked;
	logic                out_free;
	logic [TIME_W-1:0]   pos_inc;
	logic [TIME_W-1:0]   pos_back;

	lspe_ram #(
		.WIDTH (RGB_W),
		.DEPTH (MAX_LEDS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (i_q[AW-1:0]),
		.rd_data (rd_data)
	);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_b_q, out_g_q, out_r_q, out_idx_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_fin_q;

	assign half_eff = (half_q == '0) ? TIME_W'(1) : half_q;
	assign full_per = {half_eff, 1'b0};
	assign n_eff    = (count_q > COUNT_W'(MAX_LEDS)) ? COUNT_W'(MAX_LEDS) : count_q;
	assign t_in     = s_tdata;
	assign base_rgb = {base_r_q, base_g_q, base_b_q};
	assign pos_inc  = pos_q + TIME_W'(1);
	assign pos_back = pos_q - TIME_W'(2);
	assign out_free = !out_valid_q || m_tready;
	assign masked   = mask_q[i_q[4:0]];
	assign stored   = rvalid_q ? rd_data : '0;

	// triangle ramp numerator and cycle-finished flag of a new tick
	always_comb begin
		if (t_in <= half_eff) begin
			num_in = t_in;
		end else if ({1'b0, t_in} < full_per) begin
			num_in = TIME_W'(full_per - {1'b0, t_in});
		end else begin
			num_in = '0;
		end
		unique case (mode_q)
			MODE_PULSE:  fin_in = ({1'b0, t_in} >= full_per);
			MODE_CHASER: fin_in = (t_in >= TIME_W'(n_eff));
			default:     fin_in = 1'b0;
		endcase
	end

	// pulse channel multiply and one restoring divider step
	always_comb begin
		unique case (ch_q)
			2'd0:    chan = base_r_q;
			2'd1:    chan = base_g_q;
			default: chan = base_b_q;
		endcase
		prod  = {8'b0, num_q} * {16'b0, chan};
		trial = {rem_q, dvd_q[7]};
		ge    = (trial >= {1'b0, half_eff});
	end

	// colour of the LED under the cursor after the update
	always_comb begin
		unique case (tmode_q)
			MODE_OFF:    new_rgb = '0;
			MODE_STEADY: new_rgb = !masked ? base_rgb : (mask_q[31] ? stored : '0);
			MODE_PULSE:  new_rgb = masked ? '0 : {pr_q, pg_q, pb_q};
			default:     new_rgb = stored;
		endcase
	end

	// store write port
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = i_q[AW-1:0];
		wr_data = new_rgb;
		unique case (state_q)
			ST_CH_SET: begin
				wr_en   = (pos_q < TIME_W'(MAX_LEDS));
				wr_addr = pos_q[AW-1:0];
				wr_data = base_rgb;
			end
			ST_CH_CLR: begin
				wr_en   = (pos_q >= TIME_W'(2)) && (pos_back < TIME_W'(MAX_LEDS));
				wr_addr = pos_back[AW-1:0];
				wr_data = '0;
			end
			ST_WB: begin
				wr_en = out_free;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_OFF;
			base_r_q <= '0;
			base_g_q <= '0;
			base_b_q <= '0;
			mask_q   <= '0;
			count_q  <= COUNT_W'(32);
			half_q   <= TIME_W'(100);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:       mode_q   <= mode_t'(cfg_data[1:0]);
				REG_BASE_RED:   base_r_q <= cfg_data[7:0];
				REG_BASE_GREEN: base_g_q <= cfg_data[7:0];
				REG_BASE_BLUE:  base_b_q <= cfg_data[7:0];
				REG_LED_MASK:   mask_q   <= cfg_data[31:0];
				REG_LED_COUNT:  count_q  <= cfg_data[COUNT_W-1:0];
				REG_HALF_PER:   half_q   <= cfg_data[TIME_W-1:0];
				default:        ;
			endcase
		end
	end

	// payload registers of the pulse divider
	always_ff @(posedge clk) begin
		if (state_q == ST_P_MUL) begin
			rem_q <= prod[23:8];
			dvd_q <= prod[7:0];
		end else if (state_q == ST_P_DIV) begin
			rem_q <= ge ? TIME_W'(trial - {1'b0, half_eff}) : trial[TIME_W-1:0];
			dvd_q <= {dvd_q[6:0], ge};
		end
		rvalid_q <= valid_q[i_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tmode_q     <= MODE_OFF;
			pos_q       <= '0;
			num_q       <= '0;
			n_q         <= '0;
			i_q         <= '0;
			fin_q       <= 1'b0;
			ch_q        <= '0;
			step_q      <= '0;
			pr_q        <= '0;
			pg_q        <= '0;
			pb_q        <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_r_q     <= '0;
			out_g_q     <= '0;
			out_b_q     <= '0;
			out_last_q  <= 1'b0;
			out_fin_q   <= 1'b0;
		end else begin
			if (state_q == ST_WB && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == KIND_RESTART) begin
							pos_q <= '0;
						end else begin
							tmode_q <= mode_q;
							num_q   <= num_in;
							n_q     <= n_eff;
							fin_q   <= fin_in;
							i_q     <= '0;
							ch_q    <= '0;
							priority if (mode_q == MODE_CHASER && pos_q == t_in) begin
								state_q <= ST_CH_SET;
							end else if (mode_q == MODE_PULSE) begin
								state_q <= ST_P_MUL;
							end else if (n_eff != '0) begin
								state_q <= ST_RD;
							end else begin
								state_q <= ST_IDLE;
							end
						end
					end
				end
				ST_CH_SET: begin
					pos_q   <= pos_inc;
					state_q <= ST_CH_CLR;
				end
				ST_CH_CLR: begin
					state_q <= (n_q != '0) ? ST_RD : ST_IDLE;
				end
				ST_P_MUL: begin
					step_q  <= '0;
					state_q <= ST_P_DIV;
				end
				ST_P_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						unique case (ch_q)
							2'd0:    pr_q <= {dvd_q[6:0], ge};
							2'd1:    pg_q <= {dvd_q[6:0], ge};
							default: pb_q <= {dvd_q[6:0], ge};
						endcase
						ch_q <= ch_q + 2'd1;
						if (ch_q == 2'd2) begin
							state_q <= (n_q != '0) ? ST_RD : ST_IDLE;
						end else begin
							state_q <= ST_P_MUL;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					// hold the colour until the output register is free
					if (out_free) begin
						out_idx_q   <= i_q[4:0];
						out_r_q     <= new_rgb[23:16];
						out_g_q     <= new_rgb[15:8];
						out_b_q     <= new_rgb[7:0];
						out_last_q  <= (COUNT_W'(i_q + COUNT_W'(1)) == n_q);
						out_fin_q   <= fin_q;
						i_q         <= COUNT_W'(i_q + COUNT_W'(1));
						state_q     <= (COUNT_W'(i_q + COUNT_W'(1)) == n_q) ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
